// ===== rtl/rjop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjop_pkg
// Shared types, event codes and character helpers of the restricted JSON
// object parser.
// ----------------------------------------------------------------------------
package rjop_pkg;

   typedef enum logic [4:0] {
      PH_OPEN        = 5'd0,
      PH_KEY_OR_END  = 5'd1,
      PH_KEY_START   = 5'd2,
      PH_KEY         = 5'd3,
      PH_KEY_ESC     = 5'd4,
      PH_COLON       = 5'd5,
      PH_VALUE       = 5'd6,
      PH_STR         = 5'd7,
      PH_STR_ESC     = 5'd8,
      PH_ARR_FIRST   = 5'd9,
      PH_ARR_ITEM    = 5'd10,
      PH_ITEM        = 5'd11,
      PH_ITEM_ESC    = 5'd12,
      PH_ARR_NEXT    = 5'd13,
      PH_LIT         = 5'd14,
      PH_NUM_SIGN    = 5'd15,
      PH_NUM         = 5'd16,
      PH_AFTER_VALUE = 5'd17,
      PH_DONE        = 5'd18
   } phase_type;

   typedef logic [3:0] event_type;

   localparam event_type EV_NONE      = 4'd0;
   localparam event_type EV_KEY_CHAR  = 4'd1;
   localparam event_type EV_KEY_END   = 4'd2;
   localparam event_type EV_STR_CHAR  = 4'd3;
   localparam event_type EV_STR_END   = 4'd4;
   localparam event_type EV_ARR_BEGIN = 4'd5;
   localparam event_type EV_ITEM_CHAR = 4'd6;
   localparam event_type EV_ITEM_END  = 4'd7;
   localparam event_type EV_ARR_END   = 4'd8;
   localparam event_type EV_NULL      = 4'd9;
   localparam event_type EV_BOOL      = 4'd10;
   localparam event_type EV_NUMBER    = 4'd11;
   localparam event_type EV_ACCEPT    = 4'd12;
   localparam event_type EV_ERROR     = 4'd13;

   localparam logic [1:0] LIT_NULL  = 2'd0;
   localparam logic [1:0] LIT_TRUE  = 2'd1;
   localparam logic [1:0] LIT_FALSE = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      event_type         event_res;
      logic signed [63:0] payload;
      logic              run_last;
   } result_type;

   // results of one byte, compacted into the low slots
   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } push_type;

   typedef struct packed {
      logic [2:0] fill;
   } queue_status_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h09);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] kind);
      return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      unique case (kind)
         LIT_NULL: begin
            unique case (pos)
               3'd0: c = "n";
               3'd1: c = "u";
               3'd2: c = "l";
               3'd3: c = "l";
               default: c = 8'h00;
            endcase
         end
         LIT_TRUE: begin
            unique case (pos)
               3'd0: c = "t";
               3'd1: c = "r";
               3'd2: c = "u";
               3'd3: c = "e";
               default: c = 8'h00;
            endcase
         end
         LIT_FALSE: begin
            unique case (pos)
               3'd0: c = "f";
               3'd1: c = "a";
               3'd2: c = "l";
               3'd3: c = "s";
               3'd4: c = "e";
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/rjop_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjop_parse_core
// Input beat register and the parser state; one byte is decoded per cycle,
// while the result queue has room, into at most two results.
// ----------------------------------------------------------------------------
module rjop_parse_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] byte_req
   input  logic              req_tlast,   // end_of_doc
   input  logic              space_ok,
   output rjop_pkg::push_type push
);
   import rjop_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             fire;

   phase_type        phase_ff, phase_in;
   logic [1:0]       kind_ff, kind_in;
   logic [2:0]       pos_ff, pos_in;
   logic             neg_ff, neg_in;
   logic [63:0]      accum_ff, accum_in;
   logic             err_ff, err_in;

   logic [7:0]       b;
   logic             a_valid;
   event_type        a_event;
   logic [63:0]      a_payload;
   event_type        end_event;
   logic [3:0]       digit;
   logic [67:0]      product;
   logic [67:0]      limit;
   logic [2:0]       pos_next;
   event_type        char_ev;
   event_type        end_ev;
   phase_type        esc_ph;
   phase_type        body_ph;
   phase_type        next_ph;
   logic [7:0]       esc_char;
   logic             esc_ok;

   assign fire       = in_valid_ff && space_ok;
   assign req_tready = !in_valid_ff || fire;
   assign b          = in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         kind_ff  <= 2'd0;
         pos_ff   <= 3'd0;
         neg_ff   <= 1'b0;
         accum_ff <= 64'd0;
         err_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         accum_ff <= accum_in;
         err_ff   <= err_in;
      end
   end

   // accum * 10 + digit, checked against the signed range
   assign digit   = b[3:0] - 4'd0;
   assign product = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} + {64'd0, digit};
   assign limit   = neg_ff ? {4'd0, 1'b1, 63'd0}
                           : {5'd0, {63{1'b1}}};
   assign pos_next = pos_ff + 3'd1;

   // per-string-kind selections
   always_comb begin
      char_ev = EV_KEY_CHAR;
      end_ev  = EV_KEY_END;
      esc_ph  = PH_KEY_ESC;
      body_ph = PH_KEY;
      next_ph = PH_COLON;
      if (phase_ff == PH_STR || phase_ff == PH_STR_ESC) begin
         char_ev = EV_STR_CHAR;
         end_ev  = EV_STR_END;
         esc_ph  = PH_STR_ESC;
         body_ph = PH_STR;
         next_ph = PH_AFTER_VALUE;
      end else if (phase_ff == PH_ITEM || phase_ff == PH_ITEM_ESC) begin
         char_ev = EV_ITEM_CHAR;
         end_ev  = EV_ITEM_END;
         esc_ph  = PH_ITEM_ESC;
         body_ph = PH_ITEM;
         next_ph = PH_ARR_NEXT;
      end
      esc_ok   = 1'b1;
      esc_char = b;
      unique case (b)
         8'h5C:   esc_char = 8'h5C;
         8'h22:   esc_char = 8'h22;
         8'h6E:   esc_char = 8'h0A;
         8'h72:   esc_char = 8'h0D;
         8'h74:   esc_char = 8'h09;
         default: esc_ok   = 1'b0;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      neg_in    = neg_ff;
      accum_in  = accum_ff;
      err_in    = err_ff;
      a_valid   = 1'b0;
      a_event   = EV_NONE;
      a_payload = 64'd0;
      if (!err_ff) begin
         unique case (phase_ff)
            PH_OPEN: begin
               if (b == "{") phase_in = PH_KEY_OR_END;
               else if (!is_ws(b)) err_in = 1'b1;
            end
            PH_KEY_OR_END: begin
               if (b == "}") phase_in = PH_DONE;
               else if (b == 8'h22) phase_in = PH_KEY;
               else if (!is_ws(b)) err_in = 1'b1;
            end
            PH_KEY_START: begin
               if (b == 8'h22) phase_in = PH_KEY;
               else if (!is_ws(b)) err_in = 1'b1;
            end
            PH_KEY, PH_STR, PH_ITEM: begin
               if (b == 8'h22) begin
                  a_valid  = 1'b1;
                  a_event  = end_ev;
                  phase_in = next_ph;
               end else if (b == 8'h5C) begin
                  phase_in = esc_ph;
               end else begin
                  a_valid   = 1'b1;
                  a_event   = char_ev;
                  a_payload = {56'd0, b};
               end
            end
            PH_KEY_ESC, PH_STR_ESC, PH_ITEM_ESC: begin
               if (esc_ok) begin
                  a_valid   = 1'b1;
                  a_event   = char_ev;
                  a_payload = {56'd0, esc_char};
                  phase_in  = body_ph;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_COLON: begin
               if (b == ":") phase_in = PH_VALUE;
               else if (!is_ws(b)) err_in = 1'b1;
            end
            PH_VALUE: begin
               if (is_ws(b)) begin
                  phase_in = PH_VALUE;
               end else if (b == 8'h22) begin
                  phase_in = PH_STR;
               end else if (b == "[") begin
                  a_valid  = 1'b1;
                  a_event  = EV_ARR_BEGIN;
                  phase_in = PH_ARR_FIRST;
               end else if (b == "n" || b == "t" || b == "f") begin
                  kind_in  = (b == "n") ? LIT_NULL : (b == "t") ? LIT_TRUE : LIT_FALSE;
                  pos_in   = 3'd1;
                  phase_in = PH_LIT;
               end else if (b == "-") begin
                  neg_in   = 1'b1;
                  accum_in = 64'd0;
                  phase_in = PH_NUM_SIGN;
               end else if (is_digit(b)) begin
                  neg_in   = 1'b0;
                  accum_in = {60'd0, digit};
                  phase_in = PH_NUM;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_ARR_FIRST, PH_ARR_NEXT: begin
               if (b == "]") begin
                  a_valid  = 1'b1;
                  a_event  = EV_ARR_END;
                  phase_in = PH_AFTER_VALUE;
               end else if (phase_ff == PH_ARR_FIRST && b == 8'h22) begin
                  phase_in = PH_ITEM;
               end else if (phase_ff == PH_ARR_NEXT && b == ",") begin
                  phase_in = PH_ARR_ITEM;
               end else if (!is_ws(b)) begin
                  err_in = 1'b1;
               end
            end
            PH_ARR_ITEM: begin
               if (b == 8'h22) phase_in = PH_ITEM;
               else if (!is_ws(b)) err_in = 1'b1;
            end
            PH_LIT: begin
               if (kind_ff > LIT_FALSE || pos_ff >= lit_len(kind_ff)
                   || b != lit_char(kind_ff, pos_ff)) begin
                  err_in = 1'b1;
               end else begin
                  pos_in = pos_next;
                  if (pos_next == lit_len(kind_ff)) begin
                     a_valid   = 1'b1;
                     a_event   = (kind_ff == LIT_NULL) ? EV_NULL : EV_BOOL;
                     a_payload = {63'd0, kind_ff == LIT_TRUE};
                     phase_in  = PH_AFTER_VALUE;
                  end
               end
            end
            PH_NUM_SIGN: begin
               if (is_digit(b)) begin
                  accum_in = {60'd0, digit};
                  phase_in = PH_NUM;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_NUM: begin
               if (is_digit(b)) begin
                  if (product > limit) err_in = 1'b1;
                  else accum_in = product[63:0];
               end else begin
                  // emit the number, then treat this byte as after a value
                  a_valid   = 1'b1;
                  a_event   = EV_NUMBER;
                  a_payload = neg_ff ? (64'd0 - accum_ff) : accum_ff;
                  phase_in  = PH_AFTER_VALUE;
                  if (b == "}") phase_in = PH_DONE;
                  else if (b == ",") phase_in = PH_KEY_START;
                  else if (!is_ws(b)) err_in = 1'b1;
               end
            end
            PH_AFTER_VALUE: begin
               if (b == "}") phase_in = PH_DONE;
               else if (b == ",") phase_in = PH_KEY_START;
               else if (!is_ws(b)) err_in = 1'b1;
            end
            PH_DONE: begin
               if (!is_ws(b)) err_in = 1'b1;
            end
            default: err_in = 1'b1;
         endcase
      end

      end_event = (!err_in && phase_in == PH_DONE) ? EV_ACCEPT : EV_ERROR;
      if (in_last_ff) begin
         phase_in = PH_OPEN;
         kind_in  = 2'd0;
         pos_in   = 3'd0;
         neg_in   = 1'b0;
         accum_in = 64'd0;
         err_in   = 1'b0;
      end
   end

   always_comb begin
      push.slot0 = '0;
      push.slot1 = '0;
      if (a_valid) begin
         push.slot0.event_res = a_event;
         push.slot0.payload   = a_payload;
         push.slot0.run_last  = !in_last_ff;
         push.slot1.event_res = end_event;
         push.slot1.run_last  = 1'b1;
      end else begin
         push.slot0.event_res = end_event;
         push.slot0.run_last  = 1'b1;
      end
      push.count = fire ? ({1'b0, a_valid} + {1'b0, in_last_ff}) : 2'd0;
   end

endmodule

// ===== rtl/rjop_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjop_out_queue
// Result queue: takes up to two results per cycle, hands out one beat per
// cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module rjop_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  rjop_pkg::push_type        push,
   output rjop_pkg::queue_status_type status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [71:0]               rsp_tdata,  // [3:0] event_res, [67:4] payload
   output logic                      rsp_tlast   // run_last
);
   import rjop_pkg::*;

   result_type entry_ff [QUEUE_DEPTH];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [2:0] fill_ff, fill_in;
   logic       pop;
   result_type front;

   assign front      = entry_ff[head_ff];
   assign rsp_tvalid = (fill_ff != 3'd0);
   assign rsp_tdata  = {4'd0, front.payload, front.event_res};
   assign rsp_tlast  = front.run_last;
   assign pop        = rsp_tvalid && rsp_tready;
   assign status.fill = fill_ff;

   assign head_in = head_ff + {1'b0, pop};
   assign tail_in = tail_ff + push.count;
   assign fill_in = fill_ff + {1'b0, push.count} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 2'd0;
         tail_ff <= 2'd0;
         fill_ff <= 3'd0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_ff + 2'd1] <= push.slot1;
      end
   end

endmodule

// ===== rtl/restricted_json_object_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restricted_json_object_parser_unit
// Streaming tokenizer and validator of a flat JSON object, one byte a beat.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tlast       | beats
//  req     | in  | [7:0] byte_req               | end_of_doc  | one per byte
//  rsp     | out | [3:0] event_res [67:4] pay.  | run_last    | zero to two per byte
//
//  One byte is accepted per cycle while the result queue has room; its
//  results pass through the input register, then the result queue.
//  A byte giving two results sends both on the result port in order; the
//  four-entry result queue stalls input while it holds more than two results.
//  Reset is synchronous and clears the parser state and the queue.
// ----------------------------------------------------------------------------
module restricted_json_object_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_req
   input  logic        req_tlast,   // end_of_doc
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] event_res, [67:4] payload, [71:68] zero
   output logic        rsp_tlast    // run_last
);
   import rjop_pkg::*;

   push_type         push;
   queue_status_type q_status;
   logic             space_ok;

   assign space_ok = (q_status.fill <= 3'd2);

   rjop_parse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .space_ok   (space_ok),
      .push       (push)
   );

   rjop_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .status     (q_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.fill <= 3'd4) else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (q_status.fill <= 3'd2))
      else $error("push without room");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.slot0.run_last && push.slot1.run_last
         && (push.slot1.event_res == EV_ACCEPT || push.slot1.event_res == EV_ERROR)))
      else $error("bad result pair");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream check of the restricted JSON object parser: directed and
// random documents are streamed in, every token beat is predicted and
// compared in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import rjop_pkg::*;

   typedef struct {
      logic [7:0] b;
      logic       last;
   } byte_beat_type;

   typedef struct {
      event_type   ev;
      logic [63:0] pl;
      logic        rl;
   } token_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   restricted_json_object_parser_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   byte_beat_type pending_bytes[$];
   token_type     expected_tokens[$];
   int            mismatches = 0;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            hold_off_cycles;
   logic          hold_off_go;
   logic          hold_off_done;
   logic          hold_for_drain;

   // parser shadow state
   phase_type   ph = PH_OPEN;
   logic [1:0]  lit_k = 2'd0;
   logic [2:0]  lit_p = 3'd0;
   logic        neg = 1'b0;
   logic [63:0] acc = 64'd0;
   logic        err = 1'b0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic logic ws(logic [7:0] b);
      return b == 8'h20 || b == 8'h0A || b == 8'h0D || b == 8'h09;
   endfunction

   function automatic logic dig(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic [7:0] lit_at(logic [1:0] k, logic [2:0] p);
      string s;
      if (k == LIT_NULL) s = "null";
      else if (k == LIT_TRUE) s = "true";
      else s = "false";
      return (p < s.len()) ? s[p] : 8'h00;
   endfunction

   task automatic push_token(input event_type ev, input logic [63:0] pl);
      token_type t;
      t.ev = ev; t.pl = pl; t.rl = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
   endtask

   task automatic after_val(input logic [7:0] b);
      if (ws(b)) return;
      if (b == "}") ph = PH_DONE;
      else if (b == ",") ph = PH_KEY_START;
      else err = 1'b1;
   endtask

   task automatic str_body(input logic [7:0] b, input event_type ch, input event_type en,
                           input phase_type esc, input phase_type nxt);
      if (b == "\"") begin
         push_token(en, 0); ph = nxt;
      end else if (b == "\\") begin
         ph = esc;
      end else begin
         push_token(ch, {56'd0, b});
      end
   endtask

   task automatic str_esc(input logic [7:0] b, input event_type ch, input phase_type body);
      logic [7:0] c;
      case (b)
         "\\": c = "\\";
         "\"": c = "\"";
         "n": c = 8'h0A;
         "r": c = 8'h0D;
         "t": c = 8'h09;
         default: begin
            err = 1'b1;
            return;
         end
      endcase
      ph = body;
      push_token(ch, {56'd0, c});
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last);
      int          n0;
      logic [63:0] d, lim;
      n0 = expected_tokens.size();
      if (!err) begin
         case (ph)
            PH_OPEN: if (b == "{") ph = PH_KEY_OR_END; else if (!ws(b)) err = 1'b1;
            PH_KEY_OR_END: begin
               if (b == "}") ph = PH_DONE;
               else if (b == "\"") ph = PH_KEY;
               else if (!ws(b)) err = 1'b1;
            end
            PH_KEY_START: if (b == "\"") ph = PH_KEY; else if (!ws(b)) err = 1'b1;
            PH_KEY: str_body(b, EV_KEY_CHAR, EV_KEY_END, PH_KEY_ESC, PH_COLON);
            PH_KEY_ESC: str_esc(b, EV_KEY_CHAR, PH_KEY);
            PH_COLON: if (b == ":") ph = PH_VALUE; else if (!ws(b)) err = 1'b1;
            PH_VALUE: begin
               if (ws(b)) ;
               else if (b == "\"") ph = PH_STR;
               else if (b == "[") begin
                  push_token(EV_ARR_BEGIN, 0); ph = PH_ARR_FIRST;
               end else if (b == "n" || b == "t" || b == "f") begin
                  lit_k = (b == "n") ? LIT_NULL : (b == "t") ? LIT_TRUE : LIT_FALSE;
                  lit_p = 3'd1; ph = PH_LIT;
               end else if (b == "-") begin
                  neg = 1'b1; acc = 0; ph = PH_NUM_SIGN;
               end else if (dig(b)) begin
                  neg = 1'b0; acc = b - 8'h30; ph = PH_NUM;
               end else err = 1'b1;
            end
            PH_STR: str_body(b, EV_STR_CHAR, EV_STR_END, PH_STR_ESC, PH_AFTER_VALUE);
            PH_STR_ESC: str_esc(b, EV_STR_CHAR, PH_STR);
            PH_ARR_FIRST, PH_ARR_NEXT: begin
               if (b == "]") begin
                  push_token(EV_ARR_END, 0); ph = PH_AFTER_VALUE;
               end else if (ph == PH_ARR_FIRST && b == "\"") ph = PH_ITEM;
               else if (ph == PH_ARR_NEXT && b == ",") ph = PH_ARR_ITEM;
               else if (!ws(b)) err = 1'b1;
            end
            PH_ARR_ITEM: if (b == "\"") ph = PH_ITEM; else if (!ws(b)) err = 1'b1;
            PH_ITEM: str_body(b, EV_ITEM_CHAR, EV_ITEM_END, PH_ITEM_ESC, PH_ARR_NEXT);
            PH_ITEM_ESC: str_esc(b, EV_ITEM_CHAR, PH_ITEM);
            PH_LIT: begin
               if (lit_k > LIT_FALSE || b != lit_at(lit_k, lit_p)) err = 1'b1;
               else begin
                  lit_p = lit_p + 3'd1;
                  if (lit_p == ((lit_k == LIT_FALSE) ? 3'd5 : 3'd4)) begin
                     if (lit_k == LIT_NULL) push_token(EV_NULL, 0);
                     else push_token(EV_BOOL, (lit_k == LIT_TRUE) ? 64'd1 : 64'd0);
                     ph = PH_AFTER_VALUE;
                  end
               end
            end
            PH_NUM_SIGN: begin
               if (dig(b)) begin
                  acc = b - 8'h30; ph = PH_NUM;
               end else err = 1'b1;
            end
            PH_NUM: begin
               if (dig(b)) begin
                  d = b - 8'h30;
                  lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                  if (acc > (lim - d) / 10) err = 1'b1;
                  else acc = acc * 10 + d;
               end else begin
                  push_token(EV_NUMBER, neg ? -acc : acc);
                  ph = PH_AFTER_VALUE;
                  after_val(b);
               end
            end
            PH_AFTER_VALUE: after_val(b);
            PH_DONE: if (!ws(b)) err = 1'b1;
            default: err = 1'b1;
         endcase
      end
      if (last) begin
         push_token((!err && ph == PH_DONE) ? EV_ACCEPT : EV_ERROR, 0);
         ph = PH_OPEN; lit_k = 0; lit_p = 0; neg = 0; acc = 0; err = 0;
      end
      if (expected_tokens.size() > n0)
         expected_tokens[expected_tokens.size() - 1].rl = 1'b1;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) void'(pending_bytes.pop_front());
         if (req_tvalid && !req_tready) begin
            // hold the current beat
         end else if (pending_bytes.size() > 0 && !hold_for_drain &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes[0].b;
            req_tlast  <= pending_bytes[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predictor fed on accepted beats
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
   end

   // receiver ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready      <= 1'b0;
         hold_off_cycles <= 0;
         hold_off_done   <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (hold_off_go && !hold_off_done) begin
         hold_off_cycles <= 300;
         hold_off_done   <= 1'b1;
         rsp_tready      <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      token_type t;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected beat: ev=%0d pl=%h last=%b",
                                           rsp_tdata[3:0], rsp_tdata[67:4], rsp_tlast);
         end else begin
            t = expected_tokens.pop_front();
            if (rsp_tdata[3:0] !== t.ev || rsp_tdata[67:4] !== t.pl ||
                rsp_tlast !== t.rl) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch: exp ev=%0d pl=%h last=%b got ev=%0d pl=%h last=%b",
                           t.ev, t.pl, t.rl, rsp_tdata[3:0], rsp_tdata[67:4], rsp_tlast);
            end
         end
      end
   end

   task automatic add_text(input string s, input logic close_doc);
      byte_beat_type bb;
      for (int i = 0; i < s.len(); i++) begin
         bb.b = s[i];
         bb.last = close_doc && (i == s.len() - 1);
         pending_bytes.insert(pending_bytes.size(), bb);
      end
   endtask

   function automatic string rand_ws();
      string s;
      s = "";
      repeat ($urandom_range(2)) begin
         case ($urandom_range(3))
            0: s = {s, " "};
            1: s = {s, "\n"};
            2: s = {s, "\r"};
            default: s = {s, "\t"};
         endcase
      end
      return s;
   endfunction

   function automatic string rand_str();
      string s;
      byte   c;
      s = "\"";
      repeat ($urandom_range(4)) begin
         case ($urandom_range(5))
            0: begin
               case ($urandom_range(4))
                  0: c = "\\";
                  1: c = "\"";
                  2: c = "n";
                  3: c = "r";
                  default: c = "t";
               endcase
               s = {s, "\\", string'(c)};
            end
            1: begin
               c = $urandom_range(255);
               if (c == "\"" || c == "\\") c = "a";
               s = {s, string'(c)};
            end
            default: begin
               c = $urandom_range(32, 126);
               if (c == "\"" || c == "\\") c = "b";
               s = {s, string'(c)};
            end
         endcase
      end
      return {s, "\""};
   endfunction

   function automatic string rand_num();
      string s;
      case ($urandom_range(5))
         0: s = "9223372036854775807";
         1: s = "-9223372036854775808";
         2: begin
            if ($urandom_range(1)) s = "9223372036854775808";
            else s = "-9223372036854775809";
         end
         default: begin
            s = "";
            if ($urandom_range(1)) s = "-";
            repeat ($urandom_range(1, 6)) s = {s, string'(byte'($urandom_range(48, 57)))};
         end
      endcase
      return s;
   endfunction

   function automatic string rand_value();
      string s;
      case ($urandom_range(5))
         0: return rand_str();
         1: begin
            s = "[";
            for (int i = $urandom_range(3); i > 0; i--) begin
               s = {s, rand_ws(), rand_str()};
               if (i > 1) s = {s, ","};
            end
            return {s, rand_ws(), "]"};
         end
         2: return "null";
         3: begin
            if ($urandom_range(1)) return "true";
            else return "false";
         end
         default: return rand_num();
      endcase
   endfunction

   task automatic add_random_doc();
      string s;
      byte_beat_type bb;
      s = {rand_ws(), "{"};
      for (int i = $urandom_range(3); i > 0; i--) begin
         s = {s, rand_ws(), rand_str(), rand_ws(), ":", rand_ws(), rand_value(),
              rand_ws()};
         if (i > 1) s = {s, ","};
      end
      s = {s, "}", rand_ws()};
      if ($urandom_range(4) == 0) begin
         // corrupt one byte or truncate
         if ($urandom_range(1)) s[$urandom_range(s.len() - 1)] = $urandom_range(255);
         else s = s.substr(0, $urandom_range(s.len() - 1));
      end
      add_text(s, 1'b1);
      if ($urandom_range(9) == 0) begin
         for (int i = $urandom_range(1, 5); i > 0; i--) begin
            bb.b = $urandom_range(255);
            bb.last = (i == 1);
            pending_bytes.insert(pending_bytes.size(), bb);
         end
      end
   endtask

   task automatic wait_drain();
      while (pending_bytes.size() != 0 || req_tvalid || expected_tokens.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int   sent;
      int   n_before;
      logic paused;
      reset = 1'b1;
      send_idle_pct = 0; recv_idle_pct = 0;
      hold_off_go = 1'b0; hold_for_drain = 1'b0;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_text("{}", 1'b1);
      add_text(" {\"k\\n\":\"a\\\\\\\"\\r\\t\",\"x\":[ ],\"y\":[\"p\",\"q\"]", 1'b0);
      add_text(",\"n\":null,\"t\":true,\"f\":false,\"m\":-9223372036854775808", 1'b0);
      add_text(",\"z\":9223372036854775807}\n", 1'b1);
      add_text("{\"o\":9223372036854775808}", 1'b1);
      add_text("{\"a\":nul}", 1'b1);
      add_text("{\"a\":\"\\q\"}", 1'b1);
      add_text("{\"a\":007}x", 1'b1);
      add_text("{\"a\":12", 1'b1);
      add_text("{\"a\":-}", 1'b1);
      add_text({"{\"", 8'hFF, 8'h00, "\":1}"}, 1'b1);
      wait_drain();

      sent = 0;
      for (int phase_i = 0; phase_i < 4; phase_i++) begin
         send_idle_pct = (phase_i == 1 || phase_i == 3) ? 46 : 0;
         recv_idle_pct = (phase_i == 2 || phase_i == 3) ? 46 : 0;
         if (phase_i == 3) begin
            send_idle_pct = 16; recv_idle_pct = 16;
         end
         if (phase_i == 1) hold_off_go = 1'b1;
         while (sent < (phase_i + 1) * 150) begin
            n_before = pending_bytes.size();
            add_random_doc();
            sent = sent + pending_bytes.size() - n_before;
            if (phase_i == 2 && !paused && sent >= 375) begin
               // pause input until all results are out
               paused = 1'b1;
               wait_drain();
               hold_for_drain = 1'b1;
               repeat (20) @(posedge clock);
               hold_for_drain = 1'b0;
            end
         end
         wait_drain();
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
